// File: rtl/core/rmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmh_pkg
// Shared types and constants for the running median (two heaps) block.
// ----------------------------------------------------------------------------
package rmh_pkg;

  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned OUT_TDATA_W = 48;

  // command from the sequencer to one heap engine
  typedef struct packed {
    logic clr;
    logic ins;
    logic rm;
  } rmh_cmd_t;

endpackage

// File: rtl/core/running_median_two_heaps_top.sv
`timescale 1ns / 1ps
// Operation: a dropped item goes straight to its result; otherwise an item does up to
//   three heap sifts (insert, remove top, insert) before its result is loaded, each
//   sift walking the heap one level at a time.
// Throughput: one item at a time; the next item is taken the cycle after the last
//   result is loaded, while that result may still wait.
// Reset: synchronous, active low; both heaps read as empty, no result pending.
// ----------------------------------------------------------------------------
// running_median_two_heaps_top
// Running median over signed samples kept in a max-heap and a min-heap.
// ----------------------------------------------------------------------------
module running_median_two_heaps_top
  import rmh_pkg::*;
#(
  parameter int unsigned CAPACITY    = 1024,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [FIELD_W-1:0]     in_tdata,   // [31:0] sample
  input  logic                   in_tuser,   // [0] first
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [31:0] median, [42:32] sample_count
  output logic                   out_tuser   // [0] dropped
);

  localparam int unsigned SB         = SAMPLE_BITS;
  localparam int unsigned HEAP_DEPTH = CAPACITY / 2 + 2;
  localparam int unsigned SW         = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CW         = $clog2(CAPACITY + 1) + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_BAL  = 5'b00100,
    S_MOVE = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t        st_r, st_nxt;
  logic          drop_r, drop_nxt;
  logic          to_low_r, to_low_nxt;
  logic [SB-1:0] mv_r, mv_nxt;
  logic          ovalid_r;
  logic [31:0]   omed_r;
  logic [COUNT_W-1:0] ocnt_r;
  logic          odrop_r;

  rmh_cmd_t      lcmd, ucmd;
  logic [SB-1:0] lval, uval;
  logic [SB-1:0] ltop, utop;
  logic [SW-1:0] lsize, usize;
  logic          lbusy, ubusy;

  logic [SB-1:0] smp;
  logic          acc;
  logic [CW-1:0] total, total_eff;
  logic          go_low;
  logic signed [SB:0] sum, sum_adj;
  logic [SB-1:0] med_sb;
  logic [31:0]   med_out;
  logic          out_load;

  rmh_heap #(.DEPTH(HEAP_DEPTH), .SB(SB), .IS_MAX(1'b1)) u_low (
    .clk(clk), .rst_n(rst_n), .cmd(lcmd), .cmd_val(lval),
    .top(ltop), .size(lsize), .busy(lbusy)
  );

  rmh_heap #(.DEPTH(HEAP_DEPTH), .SB(SB), .IS_MAX(1'b0)) u_up (
    .clk(clk), .rst_n(rst_n), .cmd(ucmd), .cmd_val(uval),
    .top(utop), .size(usize), .busy(ubusy)
  );

  assign smp       = in_tdata[SB-1:0];
  assign in_tready = (st_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign total     = CW'(lsize) + CW'(usize);
  assign total_eff = in_tuser ? '0 : total;
  assign go_low    = in_tuser || lsize == '0 || $signed(smp) < $signed(ltop);

  assign sum     = (SB+1)'($signed(ltop)) + (SB+1)'($signed(utop));
  assign sum_adj = sum + (SB+1)'(sum[SB]);
  assign med_sb  = (lsize == usize) ? SB'(sum_adj >>> 1) : ltop;
  assign med_out = (lsize == '0) ? '0 : 32'($signed(med_sb));
  assign out_load = (st_r == S_OUT) && (!ovalid_r || out_tready);

  always_comb begin
    st_nxt     = st_r;
    drop_nxt   = drop_r;
    to_low_nxt = to_low_r;
    mv_nxt     = mv_r;
    lcmd       = '0;
    ucmd       = '0;
    lval       = smp;
    uval       = smp;
    case (st_r)
      S_IDLE: begin
        if (acc) begin
          lcmd.clr = in_tuser;
          ucmd.clr = in_tuser;
          drop_nxt = 1'b0;
          if (total_eff >= CW'(CAPACITY)) begin
            drop_nxt = 1'b1;
            st_nxt   = S_OUT;
          end else begin
            lcmd.ins = go_low;
            ucmd.ins = !go_low;
            st_nxt   = S_INS;
          end
        end
      end
      S_INS: begin
        if (!lbusy && !ubusy) begin
          st_nxt = S_BAL;
        end
      end
      S_BAL: begin
        if (lsize < usize) begin
          ucmd.rm    = 1'b1;
          mv_nxt     = utop;
          to_low_nxt = 1'b1;
          st_nxt     = S_MOVE;
        end else if (lsize > usize + SW'(1)) begin
          lcmd.rm    = 1'b1;
          mv_nxt     = ltop;
          to_low_nxt = 1'b0;
          st_nxt     = S_MOVE;
        end else begin
          st_nxt = S_OUT;
        end
      end
      S_MOVE: begin
        lval = mv_r;
        uval = mv_r;
        if (!lbusy && !ubusy) begin
          lcmd.ins = to_low_r;
          ucmd.ins = !to_low_r;
          st_nxt   = S_INS;
        end
      end
      S_OUT: begin
        if (out_load) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    drop_r   <= drop_nxt;
    to_low_r <= to_low_nxt;
    mv_r     <= mv_nxt;
    if (out_load) begin
      omed_r  <= med_out;
      ocnt_r  <= COUNT_W'(total);
      odrop_r <= drop_r;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = OUT_TDATA_W'({ocnt_r, omed_r});
  assign out_tuser  = odrop_r;

endmodule

// File: rtl/core/rmh_heap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmh_heap
// One binary heap in a synchronous memory with a sift-up / sift-down engine.
// ----------------------------------------------------------------------------
module rmh_heap
  import rmh_pkg::*;
#(
  parameter int unsigned DEPTH  = 514,
  parameter int unsigned SB     = 32,
  parameter bit          IS_MAX = 1'b1,
  localparam int unsigned AW    = $clog2(DEPTH),
  localparam int unsigned SW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rmh_cmd_t      cmd,
  input  logic [SB-1:0] cmd_val,
  output logic [SB-1:0] top,
  output logic [SW-1:0] size,
  output logic          busy
);

  typedef enum logic [5:0] {
    H_IDLE    = 6'b000001,
    H_UP_RD   = 6'b000010,
    H_UP_CMP  = 6'b000100,
    H_DN_LAST = 6'b001000,
    H_DN_RD   = 6'b010000,
    H_DN_CMP  = 6'b100000
  } hstate_t;

  hstate_t       st_r, st_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [SB-1:0] v_r, v_nxt;
  logic [SB-1:0] top_r, top_nxt;
  logic [SB-1:0] mem [DEPTH];
  logic [SB-1:0] rda_q, rdb_q;
  logic [AW-1:0] ra, rb, wa;
  logic [SB-1:0] wd;
  logic          we;
  logic [AW-1:0] par;
  logic [AW+1:0] cw, c1, n_ext;
  logic          use_b;
  logic [SB-1:0] best;
  logic [AW-1:0] bidx;

  function automatic logic above(input logic [SB-1:0] a, input logic [SB-1:0] b);
    if (IS_MAX) begin
      return $signed(a) > $signed(b);
    end else begin
      return $signed(a) < $signed(b);
    end
  endfunction

  assign par   = AW'((pos_r - AW'(1)) >> 1);
  assign cw    = (AW+2)'({pos_r, 1'b1});
  assign c1    = cw + (AW+2)'(1);
  assign n_ext = (AW+2)'(size_r);
  assign use_b = (c1 < n_ext) && above(rdb_q, rda_q);
  assign best  = use_b ? rdb_q : rda_q;
  assign bidx  = use_b ? c1[AW-1:0] : cw[AW-1:0];

  always_comb begin
    st_nxt   = st_r;
    size_nxt = size_r;
    pos_nxt  = pos_r;
    v_nxt    = v_r;
    ra       = '0;
    rb       = '0;
    we       = 1'b0;
    wa       = '0;
    wd       = v_r;
    case (st_r)
      H_IDLE: begin
        if (cmd.clr) begin
          size_nxt = '0;
        end
        if (cmd.ins) begin
          v_nxt    = cmd_val;
          pos_nxt  = cmd.clr ? '0 : AW'(size_r);
          size_nxt = cmd.clr ? SW'(1) : size_r + SW'(1);
          st_nxt   = H_UP_RD;
        end else if (cmd.rm && size_r != '0) begin
          size_nxt = size_r - SW'(1);
          if (size_r != SW'(1)) begin
            st_nxt = H_DN_LAST;
          end
        end
      end
      H_UP_RD: begin
        if (pos_r == '0) begin
          we     = 1'b1;
          wa     = '0;
          st_nxt = H_IDLE;
        end else begin
          ra     = par;
          st_nxt = H_UP_CMP;
        end
      end
      H_UP_CMP: begin
        we = 1'b1;
        wa = pos_r;
        if (above(v_r, rda_q)) begin
          wd      = rda_q;
          pos_nxt = par;
          st_nxt  = H_UP_RD;
        end else begin
          st_nxt = H_IDLE;
        end
      end
      H_DN_LAST: begin
        ra      = AW'(size_r);
        pos_nxt = '0;
        st_nxt  = H_DN_RD;
      end
      H_DN_RD: begin
        if (cw >= n_ext) begin
          we     = 1'b1;
          wa     = pos_r;
          st_nxt = H_IDLE;
        end else begin
          ra     = cw[AW-1:0];
          rb     = c1[AW-1:0];
          st_nxt = H_DN_CMP;
        end
      end
      H_DN_CMP: begin
        we = 1'b1;
        wa = pos_r;
        if (above(best, v_r)) begin
          wd      = best;
          pos_nxt = bidx;
          st_nxt  = H_DN_RD;
        end else begin
          st_nxt = H_IDLE;
        end
      end
      default: st_nxt = H_IDLE;
    endcase
  end

  // take the last entry as the carried value on the first step down
  logic [SB-1:0] v_load;
  logic          from_last_r;
  assign v_load = from_last_r ? rda_q : v_nxt;

  always_comb begin
    top_nxt = top_r;
    if (we && wa == '0) begin
      top_nxt = from_last_r ? (wd == v_r ? rda_q : wd) : wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= H_IDLE;
      size_r      <= '0;
      from_last_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      size_r      <= size_nxt;
      from_last_r <= (st_r == H_DN_LAST);
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    v_r   <= v_load;
    top_r <= top_nxt;
    if (we) begin
      mem[wa] <= (from_last_r && wd == v_r) ? rda_q : wd;
    end
    rda_q <= mem[ra];
    rdb_q <= mem[rb];
  end

  assign top  = top_r;
  assign size = size_r;
  assign busy = (st_r != H_IDLE);

endmodule

// File: rtl/core/rmh_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmh_check
// Port-level checks for the running median block, bound to the top level.
// ----------------------------------------------------------------------------
module rmh_check
  import rmh_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item withdrawn before taken");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[42:32] != '0)
    else $error("result reports an empty sample set");

endmodule

bind running_median_two_heaps_top rmh_check u_rmh_check (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
